### hw/rtl/assert_macros.svh
// Assertion macros of the queue sequencer RTL; they compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BCPQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define BCPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BCPQ_ASSERT(lbl, clk, rst_n, prop)
`define BCPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/bcpq_pkg.sv
// Shared types, codes and defaults of the bounded coalescing priority queue.
`default_nettype none
package bcpq_pkg;

  localparam int DEF_QUEUE_DEPTH     = 16;
  localparam int DEF_KEY_BITS        = 32;
  localparam int DEF_PRIORITY_LEVELS = 8;

  localparam int IN_TDATA_W  = 168;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 176;
  localparam int OUT_TUSER_W = 3;

  typedef enum logic [1:0] {
    FN_PUSH  = 2'd0,
    FN_POP   = 2'd1,
    FN_CLEAR = 2'd2,
    FN_STALE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_APPENDED  = 3'd0,
    ST_COALESCED = 3'd1,
    ST_EVICTED   = 3'd2,
    ST_DROPPED   = 3'd3,
    ST_POPPED    = 3'd4,
    ST_POP_EMPTY = 3'd5,
    ST_CLEARED   = 3'd6,
    ST_STALE     = 3'd7
  } status_t;

  typedef struct packed {
    logic shift;
    logic wr_en;
  } cell_ctl_t;

endpackage
`default_nettype wire

### hw/rtl/bounded_coalescing_priority_queue.sv
// Top level of the bounded coalescing priority queue: sequencer plus a row of entry cells.
//
//  channel | dir | ports                          | beat
//  in      | in  | in_tvalid/tready/tdata/tuser   | one operation
//  out     | out | out_tvalid/tready/tdata/tuser  | one result per operation
//
// Clear and a pop of an empty queue skip the cell row; remove-stale, an append and a drop
// make one pass over it, and a pop, a coalesce and an eviction make two. Each pass rotates
// the cell row once, one entry per cycle.
// Reset (rst_n low at a clock edge) empties the queue; the cells hold no reset value.
// A new beat is taken once the previous operation has finished, even while its result
// still waits in the output register; a stalled output holds the sequencer in its last step.
`default_nettype none
module bounded_coalescing_priority_queue
  import bcpq_pkg::*;
#(
  parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH,
  parameter int KEY_BITS        = DEF_KEY_BITS,
  parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // entry_key[31:0], entry_priority[34:32], entry_view_epoch[98:35], entry_job_id[162:99]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // func[1:0]
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // out_key[31:0], out_priority[34:32], out_view_epoch[98:35], out_job_id[162:99],
  // removed_count[167:163], occupancy[172:168]
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  // status[2:0]
  output logic      [OUT_TUSER_W-1:0] out_tuser
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int PW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int EW = KEY_BITS + PW + 128;

  cell_ctl_t     ctl;
  logic [IW-1:0] wr_idx;
  logic [EW-1:0] wr_data;
  logic [EW-1:0] cell_q [QUEUE_DEPTH];

  bcpq_ctrl #(
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .KEY_BITS        (KEY_BITS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS),
    .IW              (IW),
    .PW              (PW),
    .EW              (EW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .head       (cell_q[0]),
    .ctl        (ctl),
    .wr_idx     (wr_idx),
    .wr_data    (wr_data)
  );

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    // The last cell has no neighbor and keeps its own value on a shift.
    bcpq_cell #(
      .IDX (g),
      .IW  (IW),
      .EW  (EW)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .wr_idx   (wr_idx),
      .wr_data  (wr_data),
      .nbr_data (cell_q[(g + 1 < QUEUE_DEPTH) ? g + 1 : g]),
      .q        (cell_q[g])
    );
  end

endmodule
`default_nettype wire

### hw/rtl/bcpq_cell.sv
// One storage cell of the queue row: loads the write beat at its index or shifts from its neighbor.
`default_nettype none
module bcpq_cell
  import bcpq_pkg::*;
#(
  parameter int IDX = 0,
  parameter int IW  = 4,
  parameter int EW  = 163
) (
  input  wire logic          clk,
  input  wire cell_ctl_t     ctl,
  input  wire logic [IW-1:0] wr_idx,
  input  wire logic [EW-1:0] wr_data,
  input  wire logic [EW-1:0] nbr_data,
  output logic      [EW-1:0] q
);

  logic [EW-1:0] entry_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en && (wr_idx == IW'(IDX))) begin
      entry_r <= wr_data;
    end else if (ctl.shift) begin
      entry_r <= nbr_data;
    end
  end

  assign q = entry_r;

endmodule
`default_nettype wire

### hw/rtl/bcpq_ctrl.sv
// Sequencer of the queue: walks the cell row as a FIFO, scanning and editing one entry per cycle.
`default_nettype none
module bcpq_ctrl
  import bcpq_pkg::*;
#(
  parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH,
  parameter int KEY_BITS        = DEF_KEY_BITS,
  parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS,
  parameter int IW              = 4,
  parameter int PW              = 3,
  parameter int EW              = 163
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  output logic      [OUT_TUSER_W-1:0] out_tuser,
  input  wire logic [EW-1:0]          head,
  output cell_ctl_t                   ctl,
  output logic      [IW-1:0]          wr_idx,
  output logic      [EW-1:0]          wr_data
);

  `include "assert_macros.svh"

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int KW = KEY_BITS;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EDIT, S_DONE} state_t;

  state_t            state_r;
  func_t             op_r;
  logic [KW-1:0]     key_r;
  logic [PW-1:0]     prio_r;
  logic [63:0]       epoch_r;
  logic [63:0]       id_r;
  logic [CW-1:0]     fill_r;
  logic [CW-1:0]     len_r;
  logic [CW-1:0]     pos_r;
  logic [CW-1:0]     target_r;
  logic [CW-1:0]     match_idx_r;
  logic [CW-1:0]     victim_idx_r;
  logic [CW-1:0]     best_idx_r;
  logic [PW-1:0]     worst_r;
  logic [PW-1:0]     best_r;
  logic              found_r;
  logic              evict_r;
  status_t           res_status_r;
  logic [EW-1:0]     res_entry_r;
  logic [CW-1:0]     res_removed_r;
  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_user_r;

  logic [KW-1:0]     h_key;
  logic [PW-1:0]     h_prio;
  logic [63:0]       h_epoch;
  logic [PW-1:0]     in_prio_sat;
  logic              step;
  logic              at_tgt;
  logic              append_now;
  logic [EW-1:0]     new_entry;
  logic [PW-1:0]     merged_prio;

  assign h_key   = head[KW-1:0];
  assign h_prio  = head[KW +: PW];
  assign h_epoch = head[KW+PW +: 64];

  always_comb begin
    if (int'(in_tdata[34:32]) > PRIORITY_LEVELS - 1) begin
      in_prio_sat = PW'(PRIORITY_LEVELS - 1);
    end else begin
      in_prio_sat = PW'(in_tdata[34:32]);
    end
  end

  assign in_tready   = (state_r == S_IDLE);
  assign step        = ((state_r == S_SCAN) || (state_r == S_EDIT)) && (pos_r < fill_r);
  assign at_tgt      = (pos_r == target_r);
  assign new_entry   = {id_r, epoch_r, prio_r, key_r};
  assign merged_prio = (prio_r < h_prio) ? prio_r : h_prio;
  assign append_now  = (state_r == S_SCAN) && !step && (op_r == FN_PUSH) && !found_r &&
                       (fill_r < CW'(QUEUE_DEPTH));

  // A rotate writes the head back behind the last live entry; a delete only shifts.
  always_comb begin
    ctl     = '0;
    wr_idx  = IW'(len_r - 1'b1);
    wr_data = head;
    if ((state_r == S_SCAN) && step) begin
      ctl.shift = 1'b1;
      ctl.wr_en = 1'b1;
    end else if ((state_r == S_EDIT) && step) begin
      ctl.shift = 1'b1;
      unique case (op_r)
        FN_PUSH: begin
          ctl.wr_en = 1'b1;
          if (at_tgt) begin
            wr_data = evict_r ? new_entry :
                      {id_r, epoch_r, merged_prio, h_key};
          end
        end
        FN_POP:   ctl.wr_en = !at_tgt;
        FN_STALE: ctl.wr_en = (h_epoch == epoch_r);
        default:  ctl.wr_en = 1'b1;
      endcase
    end else if (append_now) begin
      ctl.wr_en = 1'b1;
      wr_idx    = IW'(fill_r);
      wr_data   = new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      len_r       <= '0;
      pos_r       <= '0;
      found_r     <= 1'b0;
      evict_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // The result step either reloads the output register or keeps it, so it is left alone here.
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r          <= func_t'(in_tuser[1:0]);
            key_r         <= KW'(in_tdata[31:0]);
            prio_r        <= in_prio_sat;
            epoch_r       <= in_tdata[98:35];
            id_r          <= in_tdata[162:99];
            pos_r         <= '0;
            len_r         <= fill_r;
            found_r       <= 1'b0;
            res_entry_r   <= '0;
            res_removed_r <= '0;
            unique case (func_t'(in_tuser[1:0]))
              FN_PUSH: state_r <= S_SCAN;
              FN_POP: begin
                if (fill_r == '0) begin
                  res_status_r <= ST_POP_EMPTY;
                  state_r      <= S_DONE;
                end else begin
                  state_r <= S_SCAN;
                end
              end
              FN_CLEAR: begin
                res_removed_r <= fill_r;
                fill_r        <= '0;
                res_status_r  <= ST_CLEARED;
                state_r       <= S_DONE;
              end
              default: state_r <= S_EDIT;
            endcase
          end
        end
        S_SCAN: begin
          if (step) begin
            pos_r <= pos_r + 1'b1;
            if (!found_r && (h_key == key_r)) begin
              found_r     <= 1'b1;
              match_idx_r <= pos_r;
            end
            if ((pos_r == '0) || (h_prio > worst_r)) begin
              worst_r      <= h_prio;
              victim_idx_r <= pos_r;
            end
            if ((pos_r == '0) || (h_prio < best_r)) begin
              best_r     <= h_prio;
              best_idx_r <= pos_r;
            end
          end else begin
            pos_r <= '0;
            if (op_r == FN_POP) begin
              target_r <= best_idx_r;
              state_r  <= S_EDIT;
            end else if (found_r) begin
              target_r <= match_idx_r;
              evict_r  <= 1'b0;
              state_r  <= S_EDIT;
            end else if (append_now) begin
              fill_r       <= fill_r + 1'b1;
              res_status_r <= ST_APPENDED;
              state_r      <= S_DONE;
            end else if (prio_r < worst_r) begin
              target_r <= victim_idx_r;
              evict_r  <= 1'b1;
              state_r  <= S_EDIT;
            end else begin
              res_status_r <= ST_DROPPED;
              state_r      <= S_DONE;
            end
          end
        end
        S_EDIT: begin
          if (step) begin
            pos_r <= pos_r + 1'b1;
            if ((op_r == FN_POP) && at_tgt) begin
              res_entry_r <= head;
              len_r       <= len_r - 1'b1;
            end else if ((op_r == FN_STALE) && (h_epoch != epoch_r)) begin
              len_r <= len_r - 1'b1;
            end
          end else begin
            fill_r  <= len_r;
            state_r <= S_DONE;
            priority case (op_r)
              FN_POP:   res_status_r <= ST_POPPED;
              FN_STALE: begin
                res_status_r  <= ST_STALE;
                res_removed_r <= fill_r - len_r;
              end
              default:  res_status_r <= evict_r ? ST_EVICTED : ST_COALESCED;
            endcase
          end
        end
        default: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_user_r  <= res_status_r;
            out_data_r  <= {3'b000, 5'(fill_r), 5'(res_removed_r),
                            res_entry_r[KW+PW+64 +: 64], res_entry_r[KW+PW +: 64],
                            3'(res_entry_r[KW +: PW]), 32'(res_entry_r[KW-1:0])};
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `BCPQ_ASSERT(a_fill_bound, clk, rst_n, fill_r <= CW'(QUEUE_DEPTH))
  `BCPQ_ASSERT(a_len_shrinks, clk, rst_n, (state_r != S_EDIT) || (len_r <= fill_r))
  `BCPQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_tvalid && in_tready, state_r != S_IDLE)
  `BCPQ_ASSERT_NEXT(a_result_loaded, clk, rst_n, (state_r == S_DONE) && !out_valid_r,
                    out_valid_r)

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench of the bounded coalescing priority queue with a queue-model scoreboard.
`default_nettype none
module tb_top;
  import bcpq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEF_QUEUE_DEPTH;
  localparam int LIMIT_CYCLES = 2000000;

  typedef struct packed {
    logic [31:0] key;
    logic [2:0]  prio;
    logic [63:0] epoch;
    logic [63:0] job_id;
  } job_t;

  typedef struct {
    status_t     status;
    logic [31:0] key;
    logic [2:0]  prio;
    logic [63:0] epoch;
    logic [63:0] job_id;
    logic [4:0]  removed;
    logic [4:0]  occupancy;
  } outcome_t;

  class queue_scoreboard;
    job_t     jobs[$];
    outcome_t pending[$];
    int       errors;
    int       pops, evictions, coalesces, drops;

    // Works out the outcome of one accepted operation and queues it.
    function void note_operation(func_t fn, job_t j);
      outcome_t o;
      int hit, victim, best, kept;
      job_t rest[$];
      o = '{ST_APPENDED, 0, 0, 0, 0, 0, 0};
      case (fn)
        FN_PUSH: begin
          hit = -1;
          foreach (jobs[i]) if (hit < 0 && jobs[i].key == j.key) hit = i;
          if (hit >= 0) begin
            if (j.prio < jobs[hit].prio) jobs[hit].prio = j.prio;
            jobs[hit].epoch = j.epoch;
            jobs[hit].job_id = j.job_id;
            o.status = ST_COALESCED;
            coalesces++;
          end else if (jobs.size() < DEPTH) begin
            jobs.insert(jobs.size(), j);
            o.status = ST_APPENDED;
          end else begin
            victim = 0;
            foreach (jobs[i]) if (jobs[i].prio > jobs[victim].prio) victim = i;
            if (j.prio < jobs[victim].prio) begin
              jobs[victim] = j;
              o.status = ST_EVICTED;
              evictions++;
            end else begin
              o.status = ST_DROPPED;
              drops++;
            end
          end
        end
        FN_POP: begin
          if (jobs.size() == 0) o.status = ST_POP_EMPTY;
          else begin
            best = 0;
            foreach (jobs[i]) if (jobs[i].prio < jobs[best].prio) best = i;
            o.key = jobs[best].key;
            o.prio = jobs[best].prio;
            o.epoch = jobs[best].epoch;
            o.job_id = jobs[best].job_id;
            jobs.delete(best);
            o.status = ST_POPPED;
            pops++;
          end
        end
        FN_CLEAR: begin
          o.removed = 5'(jobs.size());
          jobs.delete();
          o.status = ST_CLEARED;
        end
        default: begin
          foreach (jobs[i]) if (jobs[i].epoch == j.epoch) rest.insert(rest.size(), jobs[i]);
          kept = rest.size();
          o.removed = 5'(jobs.size() - kept);
          jobs = rest;
          o.status = ST_STALE;
        end
      endcase
      o.occupancy = 5'(jobs.size());
      pending.insert(pending.size(), o);
    endfunction

    function void check_result(logic [OUT_TUSER_W-1:0] user, logic [OUT_TDATA_W-1:0] data);
      outcome_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: status %0d", user);
        return;
      end
      e = pending.pop_front();
      if (user !== e.status || data[31:0] !== e.key || data[34:32] !== e.prio ||
          data[98:35] !== e.epoch || data[162:99] !== e.job_id ||
          data[167:163] !== e.removed || data[172:168] !== e.occupancy) begin
        errors++;
        if (errors <= 10) begin
          $write("mismatch: exp st=%0d key=%h pr=%0d ep=%h id=%h rm=%0d occ=%0d | ",
                 e.status, e.key, e.prio, e.epoch, e.job_id, e.removed, e.occupancy);
          $display("act st=%0d key=%h pr=%0d ep=%h id=%h rm=%0d occ=%0d",
                   user, data[31:0], data[34:32], data[98:35], data[162:99],
                   data[167:163], data[172:168]);
        end
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  queue_scoreboard sb;
  int  cycles = 0;
  int  sent = 0;
  bit  stall_mode;
  logic [63:0] epochs[4];
  logic [31:0] keys[8];

  bounded_coalescing_priority_queue u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The receiver alternates between long ready stretches and bursty stalls.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else begin
      if ($urandom_range(0, 199) == 0) stall_mode = ~stall_mode;
      out_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  task automatic send_op(func_t fn, job_t j);
    @(posedge clk);
    in_tvalid <= 1;
    in_tuser <= fn;
    in_tdata <= {{(IN_TDATA_W - 163){1'b0}}, j.job_id, j.epoch, j.prio, j.key};
    do @(posedge clk); while (!in_tready);
    sb.note_operation(fn, j);
    sent++;
    in_tvalid <= 0;
  endtask

  task automatic idle(int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic job_t rand_job(bit well_formed);
    job_t j;
    if (well_formed) begin
      j.key = keys[$urandom_range(0, 7)] + $urandom_range(0, 20);
      j.epoch = epochs[$urandom_range(0, 3)];
    end else begin
      j.key = $urandom();
      j.epoch = {$urandom(), $urandom()};
    end
    j.prio = 3'($urandom_range(0, 7));
    j.job_id = {$urandom(), $urandom()};
    return j;
  endfunction

  initial begin
    job_t j;
    func_t fn;
    int r, burst, n;
    bit mid_drained;
    sb = new();
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    rst_n = 0;
    n = 0;
    mid_drained = 0;
    foreach (epochs[i]) epochs[i] = {$urandom(), $urandom()};
    foreach (keys[i]) keys[i] = $urandom();
    epochs[0] = '1;
    keys[0] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty pop, extremes, coalescing, fill to full, tie drop, eviction, stale, clear.
    send_op(FN_POP, '0);
    send_op(FN_PUSH, '{32'hFFFF_FFFF, 3'd7, '1, '1});
    send_op(FN_PUSH, '{32'hFFFF_FFFF, 3'd2, 64'd0, 64'd5});
    send_op(FN_PUSH, '{32'h0, 3'd0, 64'd0, 64'd0});
    for (int i = 1; i <= 14; i++) send_op(FN_PUSH, '{32'(i), 3'd6, '1, 64'(i)});
    send_op(FN_PUSH, '{32'h100, 3'd6, '1, 64'd1});
    send_op(FN_PUSH, '{32'h101, 3'd3, '1, 64'd2});
    send_op(FN_STALE, '{32'h0, 3'd0, '1, 64'd0});
    send_op(FN_POP, '0);
    send_op(FN_POP, '0);
    send_op(FN_CLEAR, '0);
    send_op(FN_CLEAR, '0);
    drain();
    idle(60);

    while (n < 900) begin
      burst = $urandom_range(1, 12);
      if ($urandom_range(0, 3) == 0) idle($urandom_range(1, 80));
      if (!mid_drained && n >= 450) begin
        drain();
        idle(60);
        mid_drained = 1;
      end
      repeat (burst) begin
        r = $urandom_range(0, 99);
        fn = r < 60 ? FN_PUSH : r < 88 ? FN_POP : r < 92 ? FN_CLEAR : FN_STALE;
        j = rand_job($urandom_range(0, 9) != 0);
        send_op(fn, j);
        n++;
      end
    end
    drain();
    idle(100);
    $display("Ran %0d queue operations in bursts under output stalls: %0d pops, %0d coalesces,",
             sent, sb.pops, sb.coalesces);
    $display("%0d evictions and %0d drops.", sb.evictions, sb.drops);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
